// File: design/hsmt_pkg.sv
// Shared types, codes and constants of the hash set member table.
package hsmt_pkg;

	localparam int KEY_W       = 32;
	localparam int KIND_W      = 2;
	localparam int TOTAL_W     = 11;
	localparam int M_TDATA_W   = 16;
	localparam int BUCKETS_DEF = 256;
	localparam int WAYS_DEF    = 4;
	localparam int QUEUE_DEPTH = 2;

	// round(0.6180339887 * 2^32)
	localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435769;

	localparam logic [KIND_W-1:0] KIND_ADD      = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CONTAINS = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic signed [KEY_W-1:0] key;
	} op_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] member_total;
		logic               status;
		logic               was_present;
	} result_t;

endpackage

// File: design/hash_set_member_table.sv
// Top level of the hash set member table.
// A set of signed 32-bit keys held in BUCKETS buckets of WAYS slots each.
// Input words arrive on the s_ channel: s_tuser carries the operation kind
// (add, remove, contains; the unused code behaves as contains) and s_tdata
// the key. Each input word produces exactly one result word on the m_
// channel: whether the key was present beforehand, whether an add was
// refused because its bucket was full, and the member count afterwards.
// The bucket is picked by Fibonacci hashing of the key; the key is added
// into the lowest free way of its bucket.
// The front part hashes the key in one register stage and writes the word
// into a two-entry queue. The back part reads one bucket row, compares all
// ways at once and writes the row back, and takes no new word from the queue
// until that read-modify-write of the bucket memory is done. A result is
// registered in the output register when its bucket row is written back.
// After reset the back part clears the bucket memory one row per cycle;
// the front still takes words into its queue, which then fills and holds
// s_tready low. When the receiver stalls, the result waits in the output
// register while the front keeps taking words until the queue is full.
module hash_set_member_table #(
	parameter int BUCKETS = hsmt_pkg::BUCKETS_DEF,
	parameter int WAYS    = hsmt_pkg::WAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] key
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] was_present, [1] status, [12:2] member_total, zeros
);
	import hsmt_pkg::*;

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int QW = BW + $bits(op_t);

	logic          f_valid, f_ready, b_valid, b_ready;
	op_t           f_op, b_op;
	logic [BW-1:0] f_bucket, b_bucket;
	result_t       res;

	hsmt_front #(
		.BUCKETS(BUCKETS),
		.BW     (BW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (f_valid),
		.q_ready (f_ready),
		.q_op    (f_op),
		.q_bucket(f_bucket)
	);

	hsmt_queue #(
		.W(QW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data ({f_bucket, f_op}),
		.rd_valid(b_valid),
		.rd_ready(b_ready),
		.rd_data ({b_bucket, b_op})
	);

	hsmt_back #(
		.BUCKETS(BUCKETS),
		.WAYS   (WAYS),
		.BW     (BW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (b_valid),
		.q_ready  (b_ready),
		.q_op     (b_op),
		.q_bucket (b_bucket),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	assign m_tdata = {(M_TDATA_W - TOTAL_W - 2)'(0), res.member_total, res.status,
	                  res.was_present};

endmodule

// File: design/hsmt_front.sv
// Front part: accepts operation words and works out their bucket.
module hsmt_front #(
	parameter int BUCKETS = 256,
	parameter int BW      = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,
	input  logic [1:0]            s_tuser,
	output logic                  q_valid,
	input  logic                  q_ready,
	output hsmt_pkg::op_t         q_op,
	output logic [BW-1:0]         q_bucket
);
	import hsmt_pkg::*;

	logic             v_s1;
	op_t              op_s1;
	logic [KEY_W-1:0] frac_s1;
	logic [KEY_W-1:0] frac_d;
	logic [KEY_W+16:0] scaled;
	logic             adv;

	assign frac_d = s_tdata * HASH_MULT;
	assign adv    = !v_s1 || q_ready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s_tvalid) begin
			op_s1.kind <= s_tuser;
			op_s1.key  <= $signed(s_tdata);
			frac_s1    <= frac_d;
		end
	end

	// Bucket is floor(frac * BUCKETS / 2^32).
	assign scaled   = {17'b0, frac_s1} * (KEY_W+17)'(BUCKETS);
	assign q_bucket = scaled[KEY_W +: BW];
	assign q_valid  = v_s1;
	assign q_op     = op_s1;

endmodule

// File: design/hsmt_queue.sv
// Short queue between the front and back parts.
module hsmt_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);
	import hsmt_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]  ent_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign wr_ready = (cnt_q != CW'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QUEUE_DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(QUEUE_DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wr_data;
		end
	end

endmodule

// File: design/hsmt_back.sv
// Back part: bucket memory, read-modify-write of one bucket per word, result register.
module hsmt_back #(
	parameter int BUCKETS = 256,
	parameter int WAYS    = 4,
	parameter int BW      = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  hsmt_pkg::op_t       q_op,
	input  logic [BW-1:0]       q_bucket,
	output logic                res_valid,
	input  logic                res_ready,
	output hsmt_pkg::result_t   res
);
	import hsmt_pkg::*;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_MODIFY = 2'd2;

	logic [1:0]                  state_q;
	logic [BW-1:0]               clr_q;
	logic [BW-1:0]               bucket_q;
	op_t                         op_q;
	logic [TOTAL_W-1:0]          count_q;
	logic                        res_valid_q;
	result_t                     res_q;

	logic [WAYS-1:0]             valid_mem [BUCKETS];
	logic [WAYS-1:0][KEY_W-1:0]  key_mem   [BUCKETS];
	logic [WAYS-1:0]             vrow_q;
	logic [WAYS-1:0][KEY_W-1:0]  krow_q;

	logic [WAYS-1:0]             match, match_first, free_first;
	logic [WAYS-1:0]             new_valid;
	logic [WAYS-1:0][KEY_W-1:0]  new_keys;
	logic                        hit, any_free, add_ok, rem_ok, refused;
	logic                        pop, out_free, commit;

	assign pop      = (state_q == ST_IDLE) && q_valid;
	assign q_ready  = (state_q == ST_IDLE);
	assign out_free = !res_valid_q || res_ready;
	assign commit   = (state_q == ST_MODIFY) && out_free;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			match[w] = vrow_q[w] && (krow_q[w] == $unsigned(op_q.key));
		end
	end

	// Lowest set bit picks the first matching and the first free way.
	assign match_first = match & (~match + 1'b1);
	assign free_first  = ~vrow_q & (vrow_q + 1'b1);
	assign hit         = |match;
	assign any_free    = ~&vrow_q;
	assign add_ok      = (op_q.kind == KIND_ADD) && !hit && any_free;
	assign refused     = (op_q.kind == KIND_ADD) && !hit && !any_free;
	assign rem_ok      = (op_q.kind == KIND_REMOVE) && hit;
	assign new_valid   = (vrow_q | (add_ok ? free_first : '0)) & ~(rem_ok ? match_first : '0);

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			new_keys[w] = (add_ok && free_first[w]) ? $unsigned(op_q.key) : krow_q[w];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (out_free && !commit) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == BW'(BUCKETS-1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_MODIFY;
					end
				end
				ST_MODIFY: begin
					if (commit) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (add_ok) begin
							count_q <= count_q + 1'b1;
						end else if (rem_ok) begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q     <= q_op;
			bucket_q <= q_bucket;
		end
		if (commit) begin
			res_q.was_present  <= hit;
			res_q.status       <= refused;
			res_q.member_total <= add_ok ? count_q + 1'b1 :
			                      rem_ok ? count_q - 1'b1 : count_q;
		end
	end

	// Bucket memory: one row per bucket, read registered, one write port.
	always_ff @(posedge clk) begin
		if (pop) begin
			vrow_q <= valid_mem[q_bucket];
			krow_q <= key_mem[q_bucket];
		end
		if (state_q == ST_CLEAR) begin
			valid_mem[clr_q] <= '0;
		end else if (commit) begin
			valid_mem[bucket_q] <= new_valid;
			key_mem[bucket_q]   <= new_keys;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: design/hsmt_checker.sv
// Port-level checks of the hash set member table, bound to the top level.
module hsmt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// A refused add never reports the key as present.
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> !m_tdata[0])
		else $error("refused add reported a present key");

	// Padding bits of the result word stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:13] == 3'd0)
		else $error("result padding not zero");

endmodule

bind hash_set_member_table hsmt_checker u_hsmt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// File: verif/tb_hash_set_member_table.sv
// Self-checking testbench for the hash set member table: predicts every reply word and compares it.
module tb_hash_set_member_table;

	import hsmt_pkg::*;

	localparam int BUCKETS     = BUCKETS_DEF;
	localparam int WAYS        = WAYS_DEF;
	localparam int SLOTS       = BUCKETS * WAYS;
	localparam int STALL_LIMIT = 4000;
	localparam int POOL_BUCKETS = 8;
	localparam int POOL_PER_BUCKET = WAYS + 2;
	localparam int POOL_SIZE   = POOL_BUCKETS * POOL_PER_BUCKET;

	// The code the block leaves unused; it must behave as a lookup.
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	// Keeps its own copy of the bucket table and the queue of replies it expects.
	class key_set_tracker;
		bit                 slot_used [SLOTS];
		logic [KEY_W-1:0]   slot_key [SLOTS];
		int unsigned        members;
		result_t            expected_replies [$];
		int                 errors;

		function new();
			foreach (slot_used[i]) begin
				slot_used[i] = 1'b0;
				slot_key[i]  = '0;
			end
			members = 0;
			errors  = 0;
		endfunction

		// Fibonacci hashing: low word of key times the golden ratio, scaled to the bucket count.
		function int unsigned hash_bucket(logic [KEY_W-1:0] key);
			logic [KEY_W-1:0] frac;
			logic [63:0]      wide;
			frac = key * HASH_MULT;
			wide = {32'd0, frac} * 64'(BUCKETS);
			return int'(wide >> 32);
		endfunction

		function void note_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
			int      base;
			int      hit;
			int      free_way;
			result_t reply;
			base     = hash_bucket(key) * WAYS;
			hit      = -1;
			free_way = -1;
			for (int w = 0; w < WAYS; w++) begin
				if (slot_used[base + w]) begin
					if (slot_key[base + w] == key && hit < 0)
						hit = w;
				end else if (free_way < 0) begin
					free_way = w;
				end
			end
			reply = '0;
			reply.was_present = (hit >= 0);
			if (kind == KIND_ADD) begin
				if (hit < 0) begin
					if (free_way < 0) begin
						reply.status = 1'b1;
					end else begin
						slot_used[base + free_way] = 1'b1;
						slot_key[base + free_way]  = key;
						members++;
					end
				end
			end else if (kind == KIND_REMOVE && hit >= 0) begin
				slot_used[base + hit] = 1'b0;
				slot_key[base + hit]  = '0;
				members--;
			end
			reply.member_total = TOTAL_W'(members);
			expected_replies = {expected_replies, reply};
		endfunction

		function void check_reply(result_t got);
			result_t want;
			if (expected_replies.size() == 0) begin
				$error("reply word with nothing expected: %h", got);
				errors++;
				return;
			end
			want = expected_replies.pop_front();
			if (got.was_present !== want.was_present) begin
				$error("was_present expected %0d actual %0d", want.was_present, got.was_present);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status expected %0d actual %0d", want.status, got.status);
				errors++;
			end
			if (got.member_total !== want.member_total) begin
				$error("member_total expected %0d actual %0d", want.member_total,
					got.member_total);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	key_set_tracker   sb = new();
	bit               quiet_stretch;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int               idle_cycles;

	hash_set_member_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Ends the run when no word moves on either side for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_hash_set_member_table: FAIL");
			$finish;
		end
	end

	function automatic logic [KEY_W-1:0] key_for_bucket(int unsigned bkt);
		logic [KEY_W-1:0] k;
		k = $urandom;
		while (sb.hash_bucket(k) != bkt)
			k = $urandom;
		return k;
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind(int add_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return KIND_SPARE;
		if (roll < 5 + add_pct)
			return KIND_ADD;
		return ($urandom_range(0, 1) == 0) ? KIND_REMOVE : KIND_CONTAINS;
	endfunction

	// Entered and left at a falling edge; the word is held until the block takes it.
	task automatic send_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
		int gap;
		gap = quiet_stretch ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= key;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_op(kind, key);
		@(negedge clk);
	endtask

	// Holds the sender back until every outstanding reply has come home.
	task automatic drain_replies();
		s_tvalid <= 1'b0;
		while (sb.expected_replies.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic random_ops(int count, int add_pct, int pool_pct);
		logic [KEY_W-1:0] key;
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0)
				quiet_stretch = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < pool_pct)
				key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				key = $urandom;
			send_op(pick_kind(add_pct), key);
		end
		quiet_stretch = 1'b0;
	endtask

	// Result side: random stalls between words, with stretches of none.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			int gap;
			gap = quiet_stretch ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			sb.check_reply(result_t'(m_tdata[12:0]));
			@(negedge clk);
		end
	end

	initial begin
		logic [KEY_W-1:0] crowd [WAYS+1];
		int unsigned      bkt;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		quiet_stretch = 1'b0;
		idle_cycles   = 0;

		// Several buckets each get more keys than they have ways, so refusals happen.
		for (int b = 0; b < POOL_BUCKETS; b++) begin
			bkt = $urandom_range(0, BUCKETS - 1);
			for (int j = 0; j < POOL_PER_BUCKET; j++)
				key_pool[b * POOL_PER_BUCKET + j] = key_for_bucket(bkt);
		end
		bkt = $urandom_range(0, BUCKETS - 1);
		foreach (crowd[i])
			crowd[i] = key_for_bucket(bkt);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: empty lookups, repeated adds, extreme keys, a full bucket.
		send_op(KIND_CONTAINS, 32'h0000_0000);
		send_op(KIND_ADD, 32'h0000_0000);
		send_op(KIND_ADD, 32'h0000_0000);
		send_op(KIND_CONTAINS, 32'h0000_0000);
		send_op(KIND_ADD, 32'h7FFF_FFFF);
		send_op(KIND_ADD, 32'h8000_0000);
		send_op(KIND_ADD, 32'hFFFF_FFFF);
		send_op(KIND_REMOVE, 32'h0000_3039);
		send_op(KIND_REMOVE, 32'h0000_0000);
		send_op(KIND_SPARE, 32'h7FFF_FFFF);
		send_op(KIND_SPARE, 32'h0000_0000);
		foreach (crowd[i])
			send_op(KIND_ADD, crowd[i]);
		send_op(KIND_ADD, crowd[WAYS]);
		// Freeing a middle way must let the refused key land in that way.
		send_op(KIND_REMOVE, crowd[1]);
		send_op(KIND_ADD, crowd[WAYS]);
		send_op(KIND_CONTAINS, crowd[1]);
		send_op(KIND_REMOVE, crowd[WAYS]);
		send_op(KIND_CONTAINS, crowd[WAYS]);
		send_op(KIND_REMOVE, 32'h8000_0000);
		drain_replies();

		// Mostly adds first so the table gains members, then churn on a small key pool.
		random_ops(800, 75, 50);
		drain_replies();
		random_ops(850, 30, 80);
		s_tvalid <= 1'b0;

		while (sb.expected_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_hash_set_member_table: PASS");
		end else begin
			$display("tb_hash_set_member_table: FAIL");
		end
		$finish;
	end

endmodule
